/* hw/rtl/kts_pkg.sv */
package kts_pkg;

  localparam int MaxKeyframes = 16;
  localparam int FracOne = 65536;

  // Item kinds carried in the action field.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_INIT  = 2'd3;

  // Easing modes; the unused code behaves as linear.
  localparam logic [1:0] EASE_LINEAR = 2'd0;
  localparam logic [1:0] EASE_IN     = 2'd1;
  localparam logic [1:0] EASE_DECEL  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_LOOP_COUNT = 1'b0;
  localparam logic REG_TRANSIENT  = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic signed [15:0] angle;
    logic [15:0] alpha;
    logic [31:0] duration;
    logic [1:0]  easing;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        updated;
    logic        is_running;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0] out_w;
    logic [15:0] out_h;
    logic signed [15:0] out_angle;
    logic [15:0] out_alpha;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // register the accepted item
    logic key_write;   // append the captured keyframe
    logic init;        // load home and last values
    logic seg_begin;   // restart at first keyframe from home
    logic seg_next;    // step to the next keyframe from last
    logic div_start;   // start the fraction divider
    logic div_step;    // one divider iteration
    logic mul_start;   // begin the channel blend sequence
    logic mul_step;    // one blend step
    logic result_load; // load the output register
    logic result_upd;  // updated flag for the result
  } kts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       seg_done;   // elapsed time exceeds active duration
    logic       div_done;
    logic       mul_done;
  } kts_sts_t;

endpackage

/* hw/rtl/kts_ram.sv */
module kts_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/kts_datapath.sv */
module kts_datapath #(
  parameter int MaxKeyframes = kts_pkg::MaxKeyframes
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kts_pkg::in_item_t   in_data,
  input  kts_pkg::kts_cmd_t   cmd,
  input  logic                go_flag,
  input  logic                run_flag,
  output kts_pkg::kts_sts_t   sts,
  output logic [$clog2(MaxKeyframes+1)-1:0] key_count,
  output logic [$clog2(MaxKeyframes+1)-1:0] active_index,
  output kts_pkg::out_item_t  out_data
);

  localparam int AW = (MaxKeyframes > 1) ? $clog2(MaxKeyframes) : 1;
  localparam int CW = $clog2(MaxKeyframes+1);

  kts_pkg::in_item_t item_r;
  logic [CW-1:0] key_count_r, key_count_nxt;
  logic [CW-1:0] active_r;
  logic [31:0]   seg_start_r;
  logic [95:0]   from_r, home_r, last_r;
  logic [95:0]   key_vals;
  logic [31:0]   key_dur;
  logic [1:0]    key_ease;
  logic [AW-1:0] waddr, raddr;
  logic          we;
  logic          blend_last;
  logic [95:0]   blend_vals_nxt;

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  assign we    = cmd.key_write && (key_count_r < CW'(MaxKeyframes));
  assign waddr = key_count_r[AW-1:0];
  assign raddr = active_r[AW-1:0];

  kts_ram #(.Width(96), .Depth(MaxKeyframes)) u_vals (
    .clk, .we, .waddr,
    .wdata({item_r.alpha, item_r.angle, item_r.size_h, item_r.size_w,
            item_r.pos_y, item_r.pos_x}),
    .raddr, .rdata(key_vals));
  kts_ram #(.Width(34), .Depth(MaxKeyframes)) u_dur (
    .clk, .we, .waddr, .wdata({item_r.easing, item_r.duration}),
    .raddr, .rdata({key_ease, key_dur}));

  // Table fill count.
  always_comb begin
    key_count_nxt = key_count_r;
    if (we) begin
      key_count_nxt = key_count_r + CW'(1);
    end else if (cmd.capture && in_data.action == kts_pkg::ACT_CLEAR) begin
      key_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else begin
      key_count_r <= key_count_nxt;
    end
  end

  // Segment position and start/home/last values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      seg_start_r <= '0;
      from_r      <= '0;
      home_r      <= '0;
      last_r      <= '0;
    end else begin
      if (cmd.init) begin
        home_r <= {item_r.alpha, item_r.angle, item_r.size_h, item_r.size_w,
                   item_r.pos_y, item_r.pos_x};
        last_r <= {item_r.alpha, item_r.angle, item_r.size_h, item_r.size_w,
                   item_r.pos_y, item_r.pos_x};
        active_r    <= '0;
        seg_start_r <= '0;
      end else if (cmd.seg_begin) begin
        active_r    <= '0;
        seg_start_r <= item_r.now_ms;
        from_r      <= home_r;
      end else if (cmd.seg_next) begin
        active_r    <= active_r + CW'(1);
        seg_start_r <= seg_start_r + key_dur;
        from_r      <= last_r;
      end
      if (cmd.mul_step && blend_last) begin
        last_r <= blend_vals_nxt;
      end
    end
  end

  logic [31:0] elapsed;
  assign elapsed = item_r.now_ms - seg_start_r;
  assign sts.seg_done = elapsed > key_dur;

  // Restoring divider: f = floor(elapsed * 2^16 / dur), 17 bits.
  logic [32:0] rem_r;
  logic [16:0] quo_r;
  logic [4:0]  div_cnt_r;
  logic        div_sat_r;
  logic [33:0] rem_sh;
  logic [16:0] frac;

  assign rem_sh = {rem_r, 1'b0};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sat_r <= (key_dur == 32'd0) || (elapsed >= key_dur);
      rem_r     <= {1'b0, elapsed};
      quo_r     <= '0;
      div_cnt_r <= 5'd0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {2'b00, key_dur}) begin
        rem_r <= 33'(rem_sh - {2'b00, key_dur});
        quo_r <= {quo_r[15:0], 1'b1};
      end else begin
        rem_r <= rem_sh[32:0];
        quo_r <= {quo_r[15:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end
  assign sts.div_done = (div_cnt_r == 5'd16);
  assign frac = div_sat_r ? 17'(kts_pkg::FracOne) : quo_r;

  // Blend sequencer: step 0 latches the weight, f or its eased square, then one
  // channel a step with one shared 34x18 signed multiplier.
  logic [2:0]  step_r;
  logic [33:0] wgt_r;       // f (scale 2^16) or t*t / f*f (scale 2^32)
  logic [95:0] acc_r;
  logic [16:0] tsel;
  logic [33:0] sq;
  logic signed [17:0] s_v, e_v, d_v;
  logic signed [17:0] base_v;
  logic signed [52:0] prod;
  logic signed [52:0] total;
  logic signed [52:0] quot;
  logic        quad;
  logic [15:0] s_raw, e_raw;
  logic        sgn;

  assign quad = (key_ease == kts_pkg::EASE_IN) || (key_ease == kts_pkg::EASE_DECEL);
  assign tsel = (key_ease == kts_pkg::EASE_DECEL) ?
                17'(17'(kts_pkg::FracOne) - frac) : frac;
  assign sq   = 34'(tsel) * 34'(tsel);

  always_comb begin
    s_raw = from_r[16*step_r[2:0]-16 +: 16];
    e_raw = key_vals[16*step_r[2:0]-16 +: 16];
    // x, y and angle are signed channels.
    sgn = (step_r == 3'd1) || (step_r == 3'd2) || (step_r == 3'd5);
    s_v = sgn ? 18'(signed'(s_raw)) : 18'(s_raw);
    e_v = sgn ? 18'(signed'(e_raw)) : 18'(e_raw);
    if (key_ease == kts_pkg::EASE_DECEL) begin
      base_v = e_v;
      d_v    = s_v - e_v;
    end else begin
      base_v = s_v;
      d_v    = e_v - s_v;
    end
    prod  = 53'(d_v) * signed'({1'b0, wgt_r});
    if (quad) begin
      total = (53'(base_v) <<< 32) + prod;
      quot  = total >>> 32;
      if (total < 0 && total[31:0] != 32'd0) quot = quot + 53'sd1;
    end else begin
      total = (53'(base_v) <<< 16) + prod;
      quot  = total >>> 16;
      if (total < 0 && total[15:0] != 16'd0) quot = quot + 53'sd1;
    end
    blend_last = (step_r == 3'd6);
    blend_vals_nxt = {quot[15:0], acc_r[95:16]};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      step_r <= 3'd0;
    end else if (cmd.mul_step) begin
      if (step_r == 3'd0) begin
        wgt_r <= quad ? sq : 34'(frac);
      end else begin
        acc_r <= blend_vals_nxt;
      end
      step_r <= step_r + 3'd1;
    end
  end
  assign sts.mul_done = (step_r == 3'd7);

  assign sts.action   = item_r.action;
  assign key_count    = key_count_r;
  assign active_index = active_r;

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data.updated    <= cmd.result_upd && go_flag;
      out_data.is_running <= run_flag;
      out_data.out_x      <= last_r[15:0];
      out_data.out_y      <= last_r[31:16];
      out_data.out_w      <= last_r[47:32];
      out_data.out_h      <= last_r[63:48];
      out_data.out_angle  <= last_r[79:64];
      out_data.out_alpha  <= last_r[95:80];
    end
  end

endmodule

/* hw/rtl/kts_control.sv */
module kts_control #(
  parameter int MaxKeyframes = kts_pkg::MaxKeyframes
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic signed [15:0] loop_count,
  input  logic              transient_mode,
  input  kts_pkg::kts_sts_t sts,
  input  logic [$clog2(MaxKeyframes+1)-1:0] key_count,
  input  logic [$clog2(MaxKeyframes+1)-1:0] active_index,
  output kts_pkg::kts_cmd_t cmd,
  output logic              go_flag,
  output logic              run_flag
);

  localparam int CW = $clog2(MaxKeyframes+1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_STEP   = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_RESULT = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_WAIT   = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic        none_r, none_nxt;
  logic        run_r, run_nxt;
  logic        go_r, go_nxt;
  logic [15:0] passes_r, passes_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        stale, at_end;

  assign stale  = !none_r && (active_index >= key_count);
  assign at_end = !none_r && (stale || (CW'(active_index + CW'(1)) >= key_count));

  always_comb begin
    state_nxt     = state_r;
    none_nxt      = none_r;
    run_nxt       = run_r;
    go_nxt        = go_r;
    passes_nxt    = passes_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        go_nxt = 1'b0;
        priority if (sts.action == kts_pkg::ACT_PUSH) begin
          cmd.key_write = 1'b1;
          state_nxt     = S_RESULT;
        end else if (sts.action == kts_pkg::ACT_INIT) begin
          cmd.init   = 1'b1;
          none_nxt   = 1'b1;
          passes_nxt = '0;
          run_nxt    = 1'b1;
          state_nxt  = S_RESULT;
        end else if (sts.action == kts_pkg::ACT_TICK && key_count != '0) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      // Keyframe RAM read for the current position lands here.
      S_CHECK: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        go_nxt    = 1'b1;
        state_nxt = S_READ;
        if (none_r || stale || sts.seg_done) begin
          if (at_end) begin
            if (loop_count == -16'sd1) begin
              none_nxt = 1'b1;
            end else if ($signed({1'b0, passes_r}) < 17'(loop_count)) begin
              passes_nxt = passes_r + 16'd1;
              none_nxt   = 1'b1;
            end else begin
              if (transient_mode) run_nxt = 1'b0;
              go_nxt    = 1'b0;
              state_nxt = S_RESULT;
            end
          end
          if (go_nxt) begin
            if (none_nxt) begin
              cmd.seg_begin = 1'b1;
            end else begin
              cmd.seg_next = 1'b1;
            end
            none_nxt = 1'b0;
          end
        end
      end
      // Wait for the new keyframe to be read, then start the divider.
      S_READ: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          cmd.mul_start = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.result_load = 1'b1;
          cmd.result_upd  = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      none_r      <= 1'b1;
      run_r       <= 1'b1;
      go_r        <= 1'b0;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      none_r      <= none_nxt;
      run_r       <= run_nxt;
      go_r        <= go_nxt;
      passes_r    <= passes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign go_flag   = go_r;
  assign run_flag  = run_nxt;

endmodule

/* hw/rtl/keyframe_tween_sequencer.sv */
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_stall   | kts_pkg::in_item_t
// out_    | output    | out_valid/out_stall | kts_pkg::out_item_t
// cfg_    | input     | APB write/read      | loop_count, transient_mode
//
// A tick runs through the 16-step fraction divider and the seven steps of
// the shared blend multiplier. Push, clear and init go from decode straight
// to the result. Reset is synchronous and active low; the keyframe table
// needs no clearing pass. The output register holds a result under out_stall
// while the next item is taken.
module keyframe_tween_sequencer #(
  parameter int MaxKeyframes = kts_pkg::MaxKeyframes
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kts_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int CW = $clog2(MaxKeyframes+1);

  logic signed [15:0] loop_count_r;
  logic               transient_r;
  kts_pkg::kts_cmd_t  cmd;
  kts_pkg::kts_sts_t  sts;
  logic [CW-1:0]      key_count, active_index;
  logic               go_flag, run_flag;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_count_r <= '0;
      transient_r  <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == kts_pkg::REG_LOOP_COUNT) begin
        loop_count_r <= cfg_pwdata[15:0];
      end else begin
        transient_r <= cfg_pwdata[0];
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == kts_pkg::REG_TRANSIENT) ?
                      {31'd0, transient_r} : {{16{loop_count_r[15]}}, loop_count_r};

  kts_control #(.MaxKeyframes(MaxKeyframes)) u_control (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .loop_count(loop_count_r), .transient_mode(transient_r),
    .sts, .key_count, .active_index, .cmd, .go_flag, .run_flag);

  kts_datapath #(.MaxKeyframes(MaxKeyframes)) u_datapath (
    .clk, .rst_n, .in_data, .cmd, .go_flag, .run_flag, .sts,
    .key_count, .active_index, .out_data);

endmodule
